@@ rtl/psrl_pkg.sv @@
`default_nettype none

package psrl_pkg;

   localparam int ADDR_W     = 32;
   localparam int TIME_W     = 32;
   localparam int ATTEMPTS_W = 16;
   localparam int VERDICT_W  = 2;
   localparam int REMOVED_W  = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [VERDICT_W-1:0] VERDICT_ALLOWED   = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_REFUSED   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_UNTRACKED = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_SWEPT     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_ATTEMPTS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SECONDS = 1'd1;

   localparam logic [ATTEMPTS_W-1:0] ATTEMPTS_MAX = '1;
   localparam logic [REMOVED_W-1:0]  REMOVED_MAX  = '1;

   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_CMP,
      CELL_SEL,
      CELL_WR,
      CELL_SHIFT
   } cell_op_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      cell_op_type             op;
      logic                    is_sweep;
      logic                    hit_any;
      logic                    sweep_go;
      logic [ADDR_W-1:0]       address;
      logic [TIME_W-1:0]       now;
      logic [TIME_W-1:0]       window;
      logic [ATTEMPTS_W-1:0]   max_attempts;
   } cell_cmd_type;

   // Priority tokens passed from each cell to the next one up the row.
   typedef struct packed {
      logic valid_seen;
      logic hit_seen;
      logic free_seen;
      logic refuse;
   } chain_type;

endpackage

`default_nettype wire

@@ rtl/per_source_connection_rate_limiter.sv @@
`default_nettype none

// Channel   Direction  Transfer when          Payload
// req_      in         req_tvalid&req_tready  tdata: source_address, now_seconds
//                                             tuser: req_type
// rsp_      out        rsp_tvalid&rsp_tready  tdata: verdict, removed_count
// csr_      in         csr_valid&csr_ready    csr_index, csr_data
//
// Steps: a check runs compare, select, update and result in that order;
// when limiting is disabled it goes straight to result; a sweep that runs
// adds a shift step that moves the removal marks out of the cell row.
// One item is in work at a time; req_ reopens as soon as the result enters
// the output register, even if rsp_ is stalled.
// Reset clears the table valid bits, the registers and the last sweep time.
module per_source_connection_rate_limiter #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [63:0]                       req_tdata,   // source_address, now_seconds
   input  wire  [0:0]                        req_tuser,   // req_type
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [15:0]                       rsp_tdata,   // verdict, removed_count, pad
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [psrl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [31:0]                       csr_data
);

   localparam int CNT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_SEL,
      ST_WR,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic [psrl_pkg::ATTEMPTS_W-1:0]     max_att_ff, max_att_in;
   logic [psrl_pkg::TIME_W-1:0]         window_ff, window_in;
   logic [psrl_pkg::TIME_W-1:0]         last_sweep_ff, last_sweep_in;
   logic                                sweep_ff, sweep_in;
   logic [psrl_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic [psrl_pkg::TIME_W-1:0]         now_ff, now_in;
   logic                                sweep_exp_ff, sweep_exp_in;
   logic                                hit_any_ff, hit_any_in;
   logic                                sweep_go_ff, sweep_go_in;
   logic [psrl_pkg::VERDICT_W-1:0]      verdict_ff, verdict_in;
   logic [psrl_pkg::REMOVED_W-1:0]      removed_ff, removed_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [15:0]                         rsp_data_ff, rsp_data_in;

   psrl_pkg::cell_cmd_type              cmd;
   psrl_pkg::chain_type                 chain [TABLE_ENTRIES+1];
   logic                                rm    [TABLE_ENTRIES+1];
   logic                                req_xfer, limit_off;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign limit_off  = (max_att_ff == '0) | (window_ff == '0);

   // Broadcast the current step to the whole row.
   always_comb begin
      unique case (state_ff)
         ST_CMP:   cmd.op = psrl_pkg::CELL_CMP;
         ST_SEL:   cmd.op = psrl_pkg::CELL_SEL;
         ST_WR:    cmd.op = psrl_pkg::CELL_WR;
         ST_SHIFT: cmd.op = psrl_pkg::CELL_SHIFT;
         default:  cmd.op = psrl_pkg::CELL_IDLE;
      endcase
      cmd.is_sweep     = sweep_ff;
      cmd.hit_any      = hit_any_ff;
      cmd.sweep_go     = sweep_go_ff;
      cmd.address      = addr_ff;
      cmd.now          = now_ff;
      cmd.window       = window_ff;
      cmd.max_attempts = max_att_ff;
   end

   assign chain[0] = '0;
   assign rm[0]    = 1'b0;

   // Cell 0 holds the lowest table index and wins every priority tie.
   for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      psrl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .chain_i (chain[gi]),
         .chain_o (chain[gi+1]),
         .rm_i    (rm[gi]),
         .rm_o    (rm[gi+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      max_att_in    = max_att_ff;
      window_in     = window_ff;
      last_sweep_in = last_sweep_ff;
      sweep_in      = sweep_ff;
      addr_in       = addr_ff;
      now_in        = now_ff;
      sweep_exp_in  = sweep_exp_ff;
      hit_any_in    = hit_any_ff;
      sweep_go_in   = sweep_go_ff;
      verdict_in    = verdict_ff;
      removed_in    = removed_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid) begin
         unique case (csr_index)
            psrl_pkg::REG_MAX_ATTEMPTS:   max_att_in = csr_data[psrl_pkg::ATTEMPTS_W-1:0];
            psrl_pkg::REG_WINDOW_SECONDS: window_in  = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sweep_in   = req_tuser[0];
               addr_in    = req_tdata[31:0];
               now_in     = req_tdata[63:32];
               removed_in = '0;
               // disabled limiting answers at once and leaves the table alone
               if (!req_tuser[0] && limit_off) begin
                  verdict_in = psrl_pkg::VERDICT_ALLOWED;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            sweep_exp_in = (now_ff - last_sweep_ff) > window_ff;
            state_in     = ST_SEL;
         end
         ST_SEL: begin
            hit_any_in  = chain[TABLE_ENTRIES].hit_seen;
            sweep_go_in = chain[TABLE_ENTRIES].valid_seen & sweep_exp_ff;
            priority if (sweep_ff) begin
               verdict_in = psrl_pkg::VERDICT_SWEPT;
            end else if (chain[TABLE_ENTRIES].hit_seen) begin
               verdict_in = chain[TABLE_ENTRIES].refuse ? psrl_pkg::VERDICT_REFUSED
                                                        : psrl_pkg::VERDICT_ALLOWED;
            end else if (chain[TABLE_ENTRIES].free_seen) begin
               verdict_in = psrl_pkg::VERDICT_ALLOWED;
            end else begin
               verdict_in = psrl_pkg::VERDICT_UNTRACKED;
            end
            state_in = ST_WR;
         end
         ST_WR: begin
            if (sweep_ff && sweep_go_ff) begin
               last_sweep_in = now_ff;
               cnt_in        = '0;
               state_in      = ST_SHIFT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            // count marks leaving the top of the row
            if (rm[TABLE_ENTRIES] && removed_ff != psrl_pkg::REMOVED_MAX) begin
               removed_in = removed_ff + 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, removed_ff, verdict_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_att_ff    <= '0;
         window_ff     <= '0;
         last_sweep_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         hit_any_ff    <= 1'b0;
         sweep_go_ff   <= 1'b0;
         sweep_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_att_ff    <= max_att_in;
         window_ff     <= window_in;
         last_sweep_ff <= last_sweep_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_any_ff    <= hit_any_in;
         sweep_go_ff   <= sweep_go_in;
         sweep_ff      <= sweep_in;
      end
      addr_ff      <= addr_in;
      now_ff       <= now_in;
      sweep_exp_ff <= sweep_exp_in;
      verdict_ff   <= verdict_in;
      removed_ff   <= removed_in;
      cnt_ff       <= cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ rtl/psrl_cell.sv @@
`default_nettype none

// One table slot. Compare, select by position in the row, update, and shift
// sweep removal marks toward the end of the row.
module psrl_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  psrl_pkg::cell_cmd_type cmd,
   input  psrl_pkg::chain_type    chain_i,
   output psrl_pkg::chain_type    chain_o,
   input  wire                    rm_i,
   output logic                   rm_o
);

   logic                                valid_ff, valid_in;
   logic [psrl_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic [psrl_pkg::TIME_W-1:0]         start_ff, start_in;
   logic [psrl_pkg::ATTEMPTS_W-1:0]     att_ff, att_in;
   logic                                rm_ff, rm_in;
   logic                                hit_ff, hit_in;
   logic                                free_ff, free_in;
   logic                                exp_ff, exp_in;
   logic                                sel_hit_ff, sel_hit_in;
   logic                                sel_free_ff, sel_free_in;
   logic [psrl_pkg::TIME_W-1:0]         elapsed;
   logic [psrl_pkg::ATTEMPTS_W-1:0]     att_next;
   logic                                sel_hit, sel_free;

   assign elapsed  = cmd.now - start_ff;
   assign att_next = (att_ff == psrl_pkg::ATTEMPTS_MAX) ? att_ff
                                                        : att_ff + 1'b1;
   assign sel_hit  = hit_ff & ~chain_i.hit_seen;
   assign sel_free = free_ff & ~chain_i.free_seen;

   assign chain_o.valid_seen = chain_i.valid_seen | valid_ff;
   assign chain_o.hit_seen   = chain_i.hit_seen | hit_ff;
   assign chain_o.free_seen  = chain_i.free_seen | free_ff;
   assign chain_o.refuse     = chain_i.refuse
                             | (sel_hit & ~exp_ff & (att_next > cmd.max_attempts));

   assign rm_o = rm_ff;

   always_comb begin
      valid_in    = valid_ff;
      addr_in     = addr_ff;
      start_in    = start_ff;
      att_in      = att_ff;
      rm_in       = rm_ff;
      hit_in      = hit_ff;
      free_in     = free_ff;
      exp_in      = exp_ff;
      sel_hit_in  = sel_hit_ff;
      sel_free_in = sel_free_ff;
      unique case (cmd.op)
         psrl_pkg::CELL_CMP: begin
            hit_in  = valid_ff & (addr_ff == cmd.address);
            free_in = ~valid_ff;
            exp_in  = elapsed > cmd.window;
         end
         psrl_pkg::CELL_SEL: begin
            sel_hit_in  = sel_hit;
            sel_free_in = sel_free;
         end
         psrl_pkg::CELL_WR: begin
            if (cmd.is_sweep) begin
               // mark and drop expired entries
               rm_in = cmd.sweep_go & valid_ff & exp_ff;
               if (cmd.sweep_go & valid_ff & exp_ff) begin
                  valid_in = 1'b0;
               end
            end else if (sel_hit_ff) begin
               if (exp_ff) begin
                  start_in = cmd.now;
                  att_in   = psrl_pkg::ATTEMPTS_W'(1);
               end else begin
                  att_in = att_next;
               end
            end else if (sel_free_ff & ~cmd.hit_any) begin
               valid_in = 1'b1;
               addr_in  = cmd.address;
               start_in = cmd.now;
               att_in   = psrl_pkg::ATTEMPTS_W'(1);
            end
         end
         psrl_pkg::CELL_SHIFT: begin
            rm_in = rm_i;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rm_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rm_ff    <= rm_in;
      end
      addr_ff     <= addr_in;
      start_ff    <= start_in;
      att_ff      <= att_in;
      hit_ff      <= hit_in;
      free_ff     <= free_in;
      exp_ff      <= exp_in;
      sel_hit_ff  <= sel_hit_in;
      sel_free_ff <= sel_free_in;
   end

endmodule

`default_nettype wire

@@ tb/tb_per_source_connection_rate_limiter.sv @@
`default_nettype none

module tb_per_source_connection_rate_limiter;

   timeunit 1ns;
   timeprecision 1ps;

   import psrl_pkg::*;

   localparam int TRACK_SLOTS   = 64;
   localparam int DRAIN_CYCLES  = TRACK_SLOTS + 16;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 40;
   localparam int POOL_SIZE     = 6;
   localparam int FILL_BURST    = TRACK_SLOTS + 6;
   // One source hammered repeatedly under the highest limit.
   localparam int SAT_ATTEMPTS  = 12;

   localparam logic REQ_CHECK = 1'b0;
   localparam logic REQ_SWEEP = 1'b1;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [REMOVED_W-1:0] removed;
   } limiter_result_type;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   // word_a carries the source address of an item or the value of a register write;
   // word_b carries the time of an item. typed rows carry their answer in the table.
   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic                   rtype;
      logic [31:0]            word_a;
      logic [31:0]            word_b;
      logic                   typed;
      logic [VERDICT_W-1:0]   verdict;
      logic [REMOVED_W-1:0]   removed;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 25;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // limiting is off after reset: allow without tracking, sweep an empty table
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'h00000000, 32'h00000000, 1'b1,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_SWEEP, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
        VERDICT_SWEPT, 7'd0},
      '{ROW_WRITE, REG_MAX_ATTEMPTS,   REQ_CHECK, 32'd2,        32'd0,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_WRITE, REG_WINDOW_SECONDS, REQ_CHECK, 32'd10,       32'd0,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      // new source, second attempt, third attempt refused on the window edge, restart
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'hFFFFFFFF, 32'd100,      1'b1,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'hFFFFFFFF, 32'd105,      1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'hFFFFFFFF, 32'd110,      1'b1,
        VERDICT_REFUSED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'hFFFFFFFF, 32'd111,      1'b0,
        VERDICT_ALLOWED, 7'd0},
      // sweep too early, then a sweep that removes the expired source
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_SWEEP, 32'h00000000, 32'd5,        1'b1,
        VERDICT_SWEPT, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_SWEEP, 32'hA5A5A5A5, 32'd200,      1'b1,
        VERDICT_SWEPT, 7'd1},
      // window that straddles the wrap of the time field
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'h00000000, 32'hFFFFFFFF, 1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'h00000000, 32'd3,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'h00000000, 32'd4,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      // zero limit disables checking but keeps the stored source
      '{ROW_WRITE, REG_MAX_ATTEMPTS,   REQ_CHECK, 32'd0,        32'd0,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'h00000000, 32'd4,        1'b1,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_WRITE, REG_MAX_ATTEMPTS,   REQ_CHECK, 32'd1,        32'd0,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_WRITE, REG_WINDOW_SECONDS, REQ_CHECK, 32'hFFFFFFFF, 32'd0,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      // widest window: nothing ever expires
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'h00000000, 32'h80000000, 1'b1,
        VERDICT_REFUSED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_SWEEP, 32'h5A5A5A5A, 32'h12345678, 1'b1,
        VERDICT_SWEPT, 7'd0},
      '{ROW_WRITE, REG_MAX_ATTEMPTS,   REQ_CHECK, 32'h0000FFFF, 32'd0,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_WRITE, REG_WINDOW_SECONDS, REQ_CHECK, 32'd1,        32'd0,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_SWEEP, 32'h00000000, 32'd202,      1'b1,
        VERDICT_SWEPT, 7'd1},
      // zero window disables checking; the table is empty again
      '{ROW_WRITE, REG_WINDOW_SECONDS, REQ_CHECK, 32'd0,        32'd0,        1'b0,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_CHECK, 32'h12345678, 32'd0,        1'b1,
        VERDICT_ALLOWED, 7'd0},
      '{ROW_ITEM,  REG_MAX_ATTEMPTS,   REQ_SWEEP, 32'h00000000, 32'd1000,     1'b1,
        VERDICT_SWEPT, 7'd0}
   };

   // DUT ports, every input driven to a known value from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata  = '0;
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [31:0]           csr_data   = '0;

   // Mirror of the limiter: configuration and source table
   logic [ATTEMPTS_W-1:0] limit_attempts;
   logic [TIME_W-1:0]     limit_window;
   logic                  track_valid [TRACK_SLOTS];
   logic [ADDR_W-1:0]     track_addr  [TRACK_SLOTS];
   logic [TIME_W-1:0]     track_start [TRACK_SLOTS];
   logic [ATTEMPTS_W-1:0] track_count [TRACK_SLOTS];
   logic [TIME_W-1:0]     last_sweep_seen;

   limiter_result_type pending_verdicts [$];
   int                 mismatch_count = 0;
   bit                 quiet_stretch  = 1'b0;
   logic [31:0]        cur_time;

   per_source_connection_rate_limiter #(
      .TABLE_ENTRIES (TRACK_SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the DUT hangs on a handshake
   initial begin
      #8ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // Gap lengths: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (quiet_stretch) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic bit window_passed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] then);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - then;
      return elapsed > limit_window;
   endfunction

   function automatic int table_fill();
      int n;
      n = 0;
      for (int i = 0; i < TRACK_SLOTS; i++)
         if (track_valid[i]) n++;
      return n;
   endfunction

   // Work out the answer to one item and advance the mirrored table
   function automatic limiter_result_type predict_outcome(logic rtype,
                                                          logic [ADDR_W-1:0] addr,
                                                          logic [TIME_W-1:0] now);
      limiter_result_type res;
      int                 hit;
      int                 hole;
      int                 gone;
      res  = '{verdict: VERDICT_ALLOWED, removed: '0};
      hit  = -1;
      hole = -1;
      gone = 0;
      if (rtype == REQ_SWEEP) begin
         res.verdict = VERDICT_SWEPT;
         // empty table or sweep too early: nothing happens
         if (table_fill() == 0 || !window_passed(now, last_sweep_seen)) return res;
         for (int i = 0; i < TRACK_SLOTS; i++) begin
            if (track_valid[i] && window_passed(now, track_start[i])) begin
               track_valid[i] = 1'b0;
               if (gone < REMOVED_MAX) gone++;
            end
         end
         last_sweep_seen = now;
         res.removed = gone[REMOVED_W-1:0];
         return res;
      end
      if (limit_attempts == '0 || limit_window == '0) return res;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
         if (track_valid[i]) begin
            if (hit < 0 && track_addr[i] == addr) hit = i;
         end else if (hole < 0) begin
            hole = i;
         end
      end
      if (hit < 0) begin
         if (hole < 0) begin
            res.verdict = VERDICT_UNTRACKED;
            return res;
         end
         track_valid[hole] = 1'b1;
         track_addr[hole]  = addr;
         track_start[hole] = now;
         track_count[hole] = ATTEMPTS_W'(1);
         return res;
      end
      if (window_passed(now, track_start[hit])) begin
         track_start[hit] = now;
         track_count[hit] = ATTEMPTS_W'(1);
         return res;
      end
      if (track_count[hit] != ATTEMPTS_MAX) track_count[hit] = track_count[hit] + 1'b1;
      if (track_count[hit] > limit_attempts) res.verdict = VERDICT_REFUSED;
      return res;
   endfunction

   // Present one item after a random gap, hold it until the transfer, log its answer.
   // A typed answer replaces the predicted one; the mirror still advances.
   task automatic send_item(input logic rtype, input logic [31:0] addr,
                            input logic [31:0] now, input bit typed,
                            input limiter_result_type typed_result);
      int                 gap;
      limiter_result_type answer;
      gap = pick_gap();
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, addr};
      req_tuser  <= rtype;
      do @(posedge clock); while (!req_tready);
      answer = predict_outcome(rtype, addr, now);
      pending_verdicts.push_back(typed ? typed_result : answer);
   endtask

   // Write one register once every answer has come back, so the DUT is idle.
   // csr_valid stays high for a following write and is dropped by the next item.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MAX_ATTEMPTS:   limit_attempts = value[ATTEMPTS_W-1:0];
         REG_WINDOW_SECONDS: limit_window   = value;
         default: ;
      endcase
   endtask

   task automatic send_plain(input logic rtype, input logic [31:0] addr,
                             input logic [31:0] now);
      send_item(rtype, addr, now, 1'b0, '0);
   endtask

   function automatic logic [ATTEMPTS_W-1:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return ATTEMPTS_MAX;
      if (roll < 30) return ATTEMPTS_W'($urandom);
      return ATTEMPTS_W'($urandom_range(1, 4));
   endfunction

   function automatic logic [TIME_W-1:0] pick_window();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      if (roll < 30) return $urandom;
      if (roll < 60) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Time steps: mostly stay inside the window, sometimes cross it, now and then jump
   function automatic logic [TIME_W-1:0] pick_step();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return '0;
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 90) begin
         if (limit_window != '0 && limit_window <= 64)
            return $urandom_range(0, int'(limit_window) + 2);
         return $urandom_range(0, 5);
      end
      return $urandom;
   endfunction

   // Response side: take results with random stalls and compare against the log
   initial begin : result_monitor
      limiter_result_type want;
      int                 hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result: verdict %0d removed_count %0d",
                      rsp_tdata[1:0], rsp_tdata[8:2]);
               mismatch_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tdata[1:0] !== want.verdict) begin
                  $error("verdict: expected %0d, actual %0d", want.verdict, rsp_tdata[1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[8:2] !== want.removed) begin
                  $error("removed_count: expected %0d, actual %0d",
                         want.removed, rsp_tdata[8:2]);
                  mismatch_count++;
               end
               if (rsp_tdata[15:9] !== '0) begin
                  $error("pad: expected %0d, actual %0d", 0, rsp_tdata[15:9]);
                  mismatch_count++;
               end
            end
         end
         if (quiet_stretch) hold = 0;
         else if (hold == 0 && $urandom_range(0, 3) == 0) hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] pool [POOL_SIZE];
      int          roll;
      int          items_left;
      int          tries;
      logic [31:0] sat_addr;
      logic [31:0] sat_time;

      // Mirror starts in the reset state
      limit_attempts  = '0;
      limit_window    = '0;
      last_sweep_seen = '0;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
         track_valid[i] = 1'b0;
         track_addr[i]  = '0;
         track_start[i] = '0;
         track_count[i] = '0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table: walk the rows in order
      quiet_stretch = ($urandom_range(0, 1) == 0);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE)
            write_reg(directed_rows[i].reg_idx, directed_rows[i].word_a);
         else
            send_item(directed_rows[i].rtype, directed_rows[i].word_a,
                      directed_rows[i].word_b, directed_rows[i].typed,
                      limiter_result_type'{verdict: directed_rows[i].verdict,
                                           removed: directed_rows[i].removed});
      end

      // Random phases: fresh settings, a pool of repeat offenders, now and then a flood
      cur_time = $urandom;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_reg(REG_MAX_ATTEMPTS, {16'h0, pick_limit()});
         write_reg(REG_WINDOW_SECONDS, pick_window());
         quiet_stretch = ($urandom_range(0, 4) == 0);
         foreach (pool[k]) pool[k] = $urandom;
         items_left = PHASE_ITEMS;
         // flood with distinct sources to drive the table full
         if ($urandom_range(0, 2) == 0) begin
            for (int k = 0; k < FILL_BURST; k++) begin
               send_plain(REQ_CHECK, $urandom, cur_time);
               cur_time += $urandom_range(0, 1);
            end
            items_left = (PHASE_ITEMS > 10) ? 10 : PHASE_ITEMS;
         end
         for (int k = 0; k < items_left; k++) begin
            cur_time += pick_step();
            roll = $urandom_range(0, 99);
            if (roll < 12)
               send_plain(REQ_SWEEP, $urandom, cur_time);
            else if (roll < 20)
               send_plain(REQ_CHECK, $urandom, cur_time);
            else
               send_plain(REQ_CHECK, pool[$urandom_range(0, POOL_SIZE - 1)], cur_time);
         end
      end

      // Empty the table with sweeps on a one-second window before the burst
      write_reg(REG_WINDOW_SECONDS, 32'd1);
      tries = 0;
      while (table_fill() != 0 && tries < 16) begin
         send_plain(REQ_SWEEP, $urandom, $urandom);
         tries++;
      end

      // Burst from one source under the highest limit and the widest window
      write_reg(REG_MAX_ATTEMPTS, {16'h0, ATTEMPTS_MAX});
      write_reg(REG_WINDOW_SECONDS, '1);
      quiet_stretch = 1'b1;
      sat_addr = $urandom;
      sat_time = $urandom;
      for (int k = 0; k < SAT_ATTEMPTS; k++)
         send_plain(REQ_CHECK, sat_addr, sat_time);
      // drop the limit by one and try the same source again
      write_reg(REG_MAX_ATTEMPTS, {16'h0, ATTEMPTS_MAX - 1'b1});
      quiet_stretch = 1'b0;
      send_plain(REQ_CHECK, sat_addr, sat_time);
      send_plain(REQ_SWEEP, $urandom, sat_time);

      // Drain: wait out every answer, then leave room for a stray one
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/psrl_pkg.sv
rtl/psrl_cell.sv
rtl/per_source_connection_rate_limiter.sv
tb/tb_per_source_connection_rate_limiter.sv
